[design/sid_pkg.sv]
// Shared constants for the tolerant segment intersection core.
// No dependencies.
package sid_pkg;
  localparam int unsigned TolW = 49;
  typedef logic [TolW-1:0] tol_t;
endpackage

[design/segment_intersection_2d_tolerant_core.sv]
// Top level of the tolerant 2D segment intersection core.
// Depends on sid_pkg, sid_front and sid_cell.
//
// channel  | dir | payload
// s_axis   | in  | tdata: a_x a_y b_x b_y p_x p_y q_x q_y
// m_axis   | out | tdata: frac_first frac_second; tuser: hit
// cfg      | in  | area_tolerance
//
// One pair per cycle while the output is not stalled; 4 front stages, then one
// division cell per fraction bit. Reset clears valid bits and tolerance.
// A stalled output beat freezes the whole pipeline; s_axis_tready drops then.
module segment_intersection_2d_tolerant_core #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a_x, a_y, b_x, b_y, p_x, p_y, q_x, q_y
  input  logic [8*COORD_BITS-1:0]               s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // frac_first, frac_second, zero pad
  output logic [((2*FRAC_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // hit
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  sid_pkg::tol_t                         cfg_data_i
);
  localparam int unsigned AW = 2 * COORD_BITS + 3;
  localparam int unsigned DW = AW + 1;
  localparam int unsigned OW = ((2 * FRAC_BITS + 7) / 8) * 8;

  sid_pkg::tol_t        tol_q;
  logic                 en;
  logic                 f_vld, f_hit;
  logic [AW-1:0]        f_num_a, f_num_b;
  logic [AW:0]          f_den_a, f_den_b;

  logic                 c_vld [FRAC_BITS+1];
  logic                 c_hit [FRAC_BITS+1];
  logic [DW-1:0]        c_ra  [FRAC_BITS+1];
  logic [DW-1:0]        c_da  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] c_qa  [FRAC_BITS+1];
  logic [DW-1:0]        c_rb  [FRAC_BITS+1];
  logic [DW-1:0]        c_db  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] c_qb  [FRAC_BITS+1];

  assign en            = !c_vld[FRAC_BITS] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  sid_front #(.CW(COORD_BITS), .AW(AW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid), .pts_i(s_axis_tdata),
    .tol_i(tol_q), .vld_o(f_vld), .hit_o(f_hit), .num_a_o(f_num_a),
    .den_a_o(f_den_a), .num_b_o(f_num_b), .den_b_o(f_den_b)
  );

  assign c_vld[0] = f_vld;
  assign c_hit[0] = f_hit;
  assign c_ra[0]  = {1'b0, f_num_a};
  assign c_da[0]  = f_den_a;
  assign c_qa[0]  = '0;
  assign c_rb[0]  = {1'b0, f_num_b};
  assign c_db[0]  = f_den_b;
  assign c_qb[0]  = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    sid_cell #(.DW(DW), .FW(FRAC_BITS)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(c_vld[i]), .hit_i(c_hit[i]),
      .rem_a_i(c_ra[i]), .den_a_i(c_da[i]), .q_a_i(c_qa[i]),
      .rem_b_i(c_rb[i]), .den_b_i(c_db[i]), .q_b_i(c_qb[i]),
      .vld_o(c_vld[i+1]), .hit_o(c_hit[i+1]),
      .rem_a_o(c_ra[i+1]), .den_a_o(c_da[i+1]), .q_a_o(c_qa[i+1]),
      .rem_b_o(c_rb[i+1]), .den_b_o(c_db[i+1]), .q_b_o(c_qb[i+1])
    );
  end

  assign m_axis_tvalid = c_vld[FRAC_BITS];
  assign m_axis_tuser  = c_hit[FRAC_BITS];
  assign m_axis_tdata  = OW'(c_hit[FRAC_BITS] ? {c_qb[FRAC_BITS], c_qa[FRAC_BITS]}
                                              : {(2*FRAC_BITS){1'b0}});

  a_nohit_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("no-hit beat carries nonzero fractions");
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output drain");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule

[design/sid_cell.sv]
// One restoring-division cell: one quotient bit for each of the two crossing fractions.
// Depends on nothing; chained by the top level.
module sid_cell #(
  parameter int unsigned DW = 52,
  parameter int unsigned FW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic          hit_i,
  input  logic [DW-1:0] rem_a_i,
  input  logic [DW-1:0] den_a_i,
  input  logic [FW-1:0] q_a_i,
  input  logic [DW-1:0] rem_b_i,
  input  logic [DW-1:0] den_b_i,
  input  logic [FW-1:0] q_b_i,
  output logic          vld_o,
  output logic          hit_o,
  output logic [DW-1:0] rem_a_o,
  output logic [DW-1:0] den_a_o,
  output logic [FW-1:0] q_a_o,
  output logic [DW-1:0] rem_b_o,
  output logic [DW-1:0] den_b_o,
  output logic [FW-1:0] q_b_o
);
  logic [DW:0] sh_a, sh_b, df_a, df_b;
  logic        ge_a, ge_b;
  logic        vld_q;

  always_comb begin
    sh_a = {rem_a_i, 1'b0};
    sh_b = {rem_b_i, 1'b0};
    df_a = sh_a - {1'b0, den_a_i};
    df_b = sh_b - {1'b0, den_b_i};
    ge_a = sh_a >= {1'b0, den_a_i};
    ge_b = sh_b >= {1'b0, den_b_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o   <= hit_i;
      den_a_o <= den_a_i;
      den_b_o <= den_b_i;
      rem_a_o <= ge_a ? df_a[DW-1:0] : sh_a[DW-1:0];
      rem_b_o <= ge_b ? df_b[DW-1:0] : sh_b[DW-1:0];
      q_a_o   <= {q_a_i[FW-2:0], ge_a};
      q_b_o   <= {q_b_i[FW-2:0], ge_b};
    end
  end

  assign vld_o = vld_q;
endmodule

[design/sid_front.sv]
// Front pipeline: differences, products, areas, magnitudes and tolerance tests.
// Depends on sid_pkg.
module sid_front #(
  parameter int unsigned CW = 24,
  parameter int unsigned AW = 2 * CW + 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [8*CW-1:0]     pts_i,
  input  sid_pkg::tol_t       tol_i,
  output logic                vld_o,
  output logic                hit_o,
  output logic [AW-1:0]       num_a_o,
  output logic [AW:0]         den_a_o,
  output logic [AW-1:0]       num_b_o,
  output logic [AW:0]         den_b_o
);
  localparam int unsigned DfW = CW + 1;
  localparam int unsigned PW  = 2 * DfW;
  localparam int unsigned MW  = (AW > sid_pkg::TolW) ? AW : sid_pkg::TolW;

  logic signed [CW-1:0]  ax, ay, bx, by, px, py, qx, qy;
  logic signed [DfW-1:0] d_d [12];
  logic signed [DfW-1:0] d_q [12];
  logic signed [PW-1:0]  p_q [8];
  logic signed [AW-1:0]  ar_q [4];
  logic [AW-1:0]         mg [4];
  logic [3:0]            vld_q;
  logic                  hit_d;

  assign ax = pts_i[0*CW +: CW];
  assign ay = pts_i[1*CW +: CW];
  assign bx = pts_i[2*CW +: CW];
  assign by = pts_i[3*CW +: CW];
  assign px = pts_i[4*CW +: CW];
  assign py = pts_i[5*CW +: CW];
  assign qx = pts_i[6*CW +: CW];
  assign qy = pts_i[7*CW +: CW];

  always_comb begin
    d_d[0]  = DfW'(bx) - DfW'(ax);
    d_d[1]  = DfW'(by) - DfW'(ay);
    d_d[2]  = DfW'(qx) - DfW'(px);
    d_d[3]  = DfW'(qy) - DfW'(py);
    d_d[4]  = DfW'(px) - DfW'(ax);
    d_d[5]  = DfW'(py) - DfW'(ay);
    d_d[6]  = DfW'(qx) - DfW'(ax);
    d_d[7]  = DfW'(qy) - DfW'(ay);
    d_d[8]  = DfW'(ax) - DfW'(px);
    d_d[9]  = DfW'(ay) - DfW'(py);
    d_d[10] = DfW'(bx) - DfW'(px);
    d_d[11] = DfW'(by) - DfW'(py);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mg[i] = ar_q[i][AW-1] ? AW'(-ar_q[i]) : AW'(ar_q[i]);
    end
    hit_d = (MW'(mg[0]) > MW'(tol_i)) && (MW'(mg[1]) > MW'(tol_i))
         && (MW'(mg[2]) > MW'(tol_i)) && (MW'(mg[3]) > MW'(tol_i))
         && (ar_q[0][AW-1] != ar_q[1][AW-1])
         && (ar_q[2][AW-1] != ar_q[3][AW-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
      // aP, aQ against edge A-B; aA, aB against edge P-Q
      p_q[0] <= PW'(d_q[4])  * PW'(d_q[1]);
      p_q[1] <= PW'(d_q[5])  * PW'(d_q[0]);
      p_q[2] <= PW'(d_q[6])  * PW'(d_q[1]);
      p_q[3] <= PW'(d_q[7])  * PW'(d_q[0]);
      p_q[4] <= PW'(d_q[8])  * PW'(d_q[3]);
      p_q[5] <= PW'(d_q[9])  * PW'(d_q[2]);
      p_q[6] <= PW'(d_q[10]) * PW'(d_q[3]);
      p_q[7] <= PW'(d_q[11]) * PW'(d_q[2]);
      for (int i = 0; i < 4; i++) begin
        ar_q[i] <= AW'(p_q[2*i]) - AW'(p_q[2*i+1]);
      end
      hit_o   <= hit_d;
      num_a_o <= mg[2];
      den_a_o <= {1'b0, mg[2]} + {1'b0, mg[3]};
      num_b_o <= mg[0];
      den_b_o <= {1'b0, mg[0]} + {1'b0, mg[1]};
    end
  end

  assign vld_o = vld_q[3];
endmodule

[tb/sv/tb_segment_intersection_2d_tolerant_core.sv]
// Testbench for segment_intersection_2d_tolerant_core: streams segment pairs, predicts
// hit and crossing fractions per pair, checks every output beat in order.
// Depends on sid_pkg and the core.
module tb_segment_intersection_2d_tolerant_core;
  localparam int unsigned CoordW = 24;
  localparam int unsigned FracW = 16;
  localparam int unsigned Latency = 4 + FracW;
  localparam int unsigned WatchdogLimit = 20000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct packed {
    coord_t qy, qx, py, px, by, bx, ay, ax;
  } seg_pair_t;
  typedef struct packed {
    logic hit;
    logic [FracW-1:0] frac_first;
    logic [FracW-1:0] frac_second;
  } crossing_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [8*CoordW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [2*FracW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  sid_pkg::tol_t cfg_data_i = '0;

  seg_pair_t pair_q[$];
  crossing_t crossing_q[$];
  sid_pkg::tol_t tolerance = '0;
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stim_done = 0;

  segment_intersection_2d_tolerant_core #(.COORD_BITS(CoordW), .FRAC_BITS(FracW)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [FracW-1:0] floor_frac(logic [63:0] num, logic [63:0] den);
    logic [127:0] scaled;
    scaled = {64'd0, num} << FracW;
    return FracW'(scaled / {64'd0, den});
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s, sid_pkg::tol_t tol);
    longint ax, ay, bx, by, px, py, qx, qy, ap, aq, aa, ab;
    logic [63:0] mp, mq, ma, mb;
    crossing_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    px = s.px; py = s.py; qx = s.qx; qy = s.qy;
    ap = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    aq = (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
    aa = (ax - px) * (qy - py) - (ay - py) * (qx - px);
    ab = (bx - px) * (qy - py) - (by - py) * (qx - px);
    mp = magnitude(ap); mq = magnitude(aq); ma = magnitude(aa); mb = magnitude(ab);
    r = '0;
    r.hit = mp > tol && mq > tol && ((ap < 0) != (aq < 0))
         && ma > tol && mb > tol && ((aa < 0) != (ab < 0));
    if (r.hit) begin
      r.frac_first = floor_frac(ma, ma + mb);
      r.frac_second = floor_frac(mp, mp + mq);
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 3) == 0 ? 24'h800000 : 24'h7fffff);
      1: return coord_t'($signed($urandom_range(0, 64)) - 32);
      2: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // crossing pair: endpoints around a common centre, mostly hits
  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int span;
    if ($urandom_range(0, 3) == 0) begin
      s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    end else begin
      span = 1 << $urandom_range(1, 21);
      s.ax = coord_t'(-$urandom_range(0, span)); s.ay = coord_t'(-$urandom_range(0, span));
      s.bx = coord_t'($urandom_range(0, span));  s.by = coord_t'($urandom_range(0, span));
      s.px = coord_t'(-$urandom_range(0, span)); s.py = coord_t'($urandom_range(0, span));
      s.qx = coord_t'($urandom_range(0, span));  s.qy = coord_t'(-$urandom_range(0, span));
      if ($urandom_range(0, 1)) s = {s.by, s.bx, s.ay, s.ax, s.qy, s.qx, s.py, s.px};
    end
    return s;
  endfunction

  task automatic write_tolerance(sid_pkg::tol_t v);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    tolerance = v;
  endtask

  task automatic drain();
    while (pair_q.size() != 0 || crossing_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic add_directed();
    coord_t mx, mn;
    mx = coord_t'(24'h7fffff); mn = coord_t'(24'h800000);
    pair_q.push_back({coord_t'(10), coord_t'(0), coord_t'(-10), coord_t'(0),
                      coord_t'(0), coord_t'(10), coord_t'(0), coord_t'(-10)});
    pair_q.push_back({mn, mx, mx, mn, mx, mx, mn, mn});
    pair_q.push_back({mx, mn, mn, mx, mn, mn, mx, mx});
    pair_q.push_back({mx, mx, mn, mn, mn, mx, mx, mn});
    pair_q.push_back({coord_t'(1), coord_t'(1), coord_t'(0), coord_t'(0),
                      coord_t'(1), coord_t'(1), coord_t'(0), coord_t'(0)});
    pair_q.push_back({coord_t'(4), coord_t'(4), coord_t'(-4), coord_t'(-4),
                      coord_t'(8), coord_t'(8), coord_t'(0), coord_t'(0)});
    pair_q.push_back({coord_t'(10), coord_t'(0), coord_t'(-10), coord_t'(0),
                      coord_t'(0), coord_t'(10), coord_t'(0), coord_t'(0)});
    pair_q.push_back({coord_t'(10), coord_t'(1), coord_t'(-10), coord_t'(1),
                      coord_t'(0), coord_t'(10), coord_t'(0), coord_t'(-10)});
    pair_q.push_back({coord_t'(0), coord_t'(10), coord_t'(0), coord_t'(-10),
                      coord_t'(10), coord_t'(0), coord_t'(-10), coord_t'(0)});
    pair_q.push_back({coord_t'(-1), coord_t'(1), coord_t'(1), coord_t'(-1),
                      coord_t'(1), coord_t'(1), coord_t'(-1), coord_t'(-1)});
    pair_q.push_back({coord_t'(3), coord_t'(-1000), coord_t'(-1), coord_t'(1000),
                      coord_t'(1), coord_t'(9), coord_t'(1), coord_t'(-1)});
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    add_directed();
    drain();
    write_tolerance('1);
    add_directed();
    for (int i = 0; i < 20; i++) pair_q.push_back(rand_pair());
    drain();
    write_tolerance(sid_pkg::tol_t'(1));
    add_directed();
    for (int i = 0; i < 200; i++) pair_q.push_back(rand_pair());
    drain();
    write_tolerance(sid_pkg::tol_t'({$urandom, $urandom}) >> $urandom_range(10, 30));
    hold_off = 300;
    for (int i = 0; i < 220; i++) pair_q.push_back(rand_pair());
    drain();
    write_tolerance('0);
    for (int i = 0; i < 220; i++) pair_q.push_back(rand_pair());
    drain();
    stim_done = 1;
  end

  function automatic int rand_gap();
    return $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) == 0 ?
           $urandom_range(10, 40) : $urandom_range(1, 3));
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      crossing_q.push_back(predict_crossing(pair_q.pop_front(), tolerance));
      send_gap = rand_gap();
    end
    if ((!s_axis_tvalid || s_axis_tready) && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 0;
      end else if (pair_q.size() != 0) begin
        s_axis_tvalid <= 1;
        s_axis_tdata <= pair_q[0];
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    crossing_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[FracW-1:0], m_axis_tdata[2*FracW-1:FracW]};
      if (crossing_q.size() == 0) begin
        $error("output beat with nothing expected");
        errors++;
      end else begin
        want = crossing_q.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d got %0d", want.hit, got.hit);
          errors++;
        end
        if (got.frac_first !== want.frac_first) begin
          $error("frac_first: expected %0d got %0d", want.frac_first, got.frac_first);
          errors++;
        end
        if (got.frac_second !== want.frac_second) begin
          $error("frac_second: expected %0d got %0d", want.frac_second, got.frac_second);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      m_axis_tready <= 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      recv_gap = rand_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || (pair_q.size() == 0 && crossing_q.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else if (stim_done) begin
      if (errors == 0 && crossing_q.size() == 0)
        $display("TB_OK");
      else
        $display("TB_ERROR");
      $finish;
    end
  end
endmodule
